// ===== rtl/uartrf_pkg.sv =====
// Shared types, constants and helpers for the UART register file with receive FIFO.
// Depends on nothing; every other file in rtl/ except uartrf_ram.sv imports it.
package uartrf_pkg;

  // Receive FIFO geometry
  localparam int RX_DEPTH = 16;
  localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

  // Command queue between front and back
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  // Item kinds
  localparam logic [1:0] ACT_RX    = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // Register offsets
  localparam logic [2:0] OFF_RBR_THR = 3'd0;
  localparam logic [2:0] OFF_IER     = 3'd1;
  localparam logic [2:0] OFF_IIR_FCR = 3'd2;
  localparam logic [2:0] OFF_LCR     = 3'd3;
  localparam logic [2:0] OFF_MCR     = 3'd4;
  localparam logic [2:0] OFF_LSR     = 3'd5;
  localparam logic [2:0] OFF_MSR     = 3'd6;
  localparam logic [2:0] OFF_SCR     = 3'd7;

  // Register bit values
  localparam logic [7:0] IIR_RX_DATA = 8'h04;
  localparam logic [7:0] IIR_THRE    = 8'h02;
  localparam logic [7:0] IIR_NONE    = 8'h01;
  localparam logic [7:0] IIR_FIFO_ID = 8'hC0;
  localparam logic [7:0] LSR_TX_IDLE = 8'h60;
  localparam logic [7:0] LSR_DR      = 8'h01;

  localparam int LCR_DLAB_BIT = 7;
  localparam int IER_RDA_BIT  = 0;
  localparam int IER_THRE_BIT = 1;
  localparam int FCR_EN_BIT   = 0;
  localparam int FCR_CLR_BIT  = 1;

  // Classified operation; offsets 0 and 1 stay unresolved until the back
  // end knows the DLAB bit at execution time.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_RX_PUSH,
    OP_RD_OFF0,
    OP_RD_OFF1,
    OP_RD_IIR,
    OP_RD_LCR,
    OP_RD_MCR,
    OP_RD_LSR,
    OP_RD_ZERO,
    OP_RD_SCR,
    OP_WR_OFF0,
    OP_WR_OFF1,
    OP_WR_FCR,
    OP_WR_LCR,
    OP_WR_MCR,
    OP_WR_SCR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [RX_PTR_W-1:0] rx_ptr_inc(input logic [RX_PTR_W-1:0] p);
    logic [RX_PTR_W-1:0] n;
    if (p == RX_PTR_W'(RX_DEPTH - 1)) n = '0;
    else n = p + 1'b1;
    return n;
  endfunction

  function automatic logic [Q_PTR_W-1:0] q_ptr_inc(input logic [Q_PTR_W-1:0] p);
    logic [Q_PTR_W-1:0] n;
    if (p == Q_PTR_W'(Q_DEPTH - 1)) n = '0;
    else n = p + 1'b1;
    return n;
  endfunction

endpackage

// ===== rtl/uartrf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module uartrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/uartrf_front.sv =====
// Front end: classifies an incoming item into a queued command.
// Depends on uartrf_pkg.
module uartrf_front (
  input  logic [1:0]        action,
  input  logic [2:0]        reg_offset,
  input  logic [7:0]        write_data,
  input  logic [7:0]        line_byte,
  output uartrf_pkg::cmd_t  cmd
);
  import uartrf_pkg::*;

  always_comb begin
    cmd.op   = OP_NOP;
    cmd.data = write_data;
    unique case (action)
      ACT_RX: begin
        cmd.op   = OP_RX_PUSH;
        cmd.data = line_byte;
      end
      ACT_READ: begin
        unique case (reg_offset)
          OFF_RBR_THR: cmd.op = OP_RD_OFF0;
          OFF_IER:     cmd.op = OP_RD_OFF1;
          OFF_IIR_FCR: cmd.op = OP_RD_IIR;
          OFF_LCR:     cmd.op = OP_RD_LCR;
          OFF_MCR:     cmd.op = OP_RD_MCR;
          OFF_LSR:     cmd.op = OP_RD_LSR;
          OFF_MSR:     cmd.op = OP_RD_ZERO;
          OFF_SCR:     cmd.op = OP_RD_SCR;
          default:     cmd.op = OP_RD_ZERO;
        endcase
      end
      ACT_WRITE: begin
        unique case (reg_offset)
          OFF_RBR_THR: cmd.op = OP_WR_OFF0;
          OFF_IER:     cmd.op = OP_WR_OFF1;
          OFF_IIR_FCR: cmd.op = OP_WR_FCR;
          OFF_LCR:     cmd.op = OP_WR_LCR;
          OFF_MCR:     cmd.op = OP_WR_MCR;
          OFF_SCR:     cmd.op = OP_WR_SCR;
          default:     cmd.op = OP_NOP;   // LSR, MSR writes are ignored
        endcase
      end
      default: cmd.op = OP_NOP;
    endcase
  end

endmodule

// ===== rtl/uartrf_cmd_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on uartrf_pkg.
module uartrf_cmd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  uartrf_pkg::cmd_t  push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output uartrf_pkg::cmd_t  pop_cmd
);
  import uartrf_pkg::*;

  cmd_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? q_ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? q_ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/uartrf_back.sv =====
// Back end: register file, receive FIFO control and the result register.
// Depends on uartrf_pkg and uartrf_ram.
module uartrf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  uartrf_pkg::cmd_t  cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_read_data,
  output logic              out_tx_valid,
  output logic [7:0]        out_tx_byte,
  output logic              out_irq_pulse
);
  import uartrf_pkg::*;

  // Register file
  logic [7:0] ier_r, ier_nxt;
  logic [7:0] lcr_r, lcr_nxt;
  logic [7:0] mcr_r, mcr_nxt;
  logic [7:0] scr_r, scr_nxt;
  logic [7:0] dll_r, dll_nxt;
  logic [7:0] dlm_r, dlm_nxt;
  logic       fifo_on_r, fifo_on_nxt;
  logic       thre_r, thre_nxt;

  // Receive FIFO control
  logic [RX_PTR_W-1:0] head_r, head_nxt;
  logic [RX_PTR_W-1:0] tail_r, tail_nxt;
  logic [RX_CNT_W-1:0] fill_r, fill_nxt;
  logic                ram_we;
  logic [7:0]          ram_rdata;
  logic                byp_valid_r;
  logic [7:0]          byp_data_r;
  logic [7:0]          head_data;

  // Result register
  logic       out_valid_r;
  logic [7:0] rdata_r, rdata_nxt;
  logic       txv_r, txv_nxt;
  logic [7:0] txb_r, txb_nxt;
  logic       irq_r, irq_nxt;

  logic fire, dlab, has_data;

  assign cmd_ready = !out_valid_r || out_ready;
  assign fire      = cmd_valid && cmd_ready;
  assign dlab      = lcr_r[LCR_DLAB_BIT];
  assign has_data  = (fill_r != '0);
  assign head_data = byp_valid_r ? byp_data_r : ram_rdata;

  always_comb begin
    ier_nxt     = ier_r;
    lcr_nxt     = lcr_r;
    mcr_nxt     = mcr_r;
    scr_nxt     = scr_r;
    dll_nxt     = dll_r;
    dlm_nxt     = dlm_r;
    fifo_on_nxt = fifo_on_r;
    thre_nxt    = thre_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    ram_we      = 1'b0;
    rdata_nxt   = '0;
    txv_nxt     = 1'b0;
    txb_nxt     = '0;
    irq_nxt     = 1'b0;
    if (fire) begin
      unique case (cmd.op)
        OP_RX_PUSH: begin
          // drop the byte when the FIFO is full
          if (fill_r != RX_CNT_W'(RX_DEPTH)) begin
            ram_we   = 1'b1;
            tail_nxt = rx_ptr_inc(tail_r);
            fill_nxt = fill_r + 1'b1;
          end
        end
        OP_RD_OFF0: begin
          if (dlab) begin
            rdata_nxt = dll_r;
          end else begin
            if (has_data) begin
              rdata_nxt = head_data;
              head_nxt  = rx_ptr_inc(head_r);
              fill_nxt  = fill_r - 1'b1;
            end
            irq_nxt = (ier_r[IER_THRE_BIT] && thre_r) ||
                      (ier_r[IER_RDA_BIT] && (fill_nxt != '0));
          end
        end
        OP_RD_OFF1: rdata_nxt = dlab ? dlm_r : ier_r;
        OP_RD_IIR: begin
          if (has_data && ier_r[IER_RDA_BIT]) begin
            rdata_nxt = IIR_RX_DATA;
          end else if (thre_r && ier_r[IER_THRE_BIT]) begin
            rdata_nxt = IIR_THRE;
            thre_nxt  = 1'b0;
          end else begin
            rdata_nxt = IIR_NONE;
          end
          if (fifo_on_r) rdata_nxt = rdata_nxt | IIR_FIFO_ID;
        end
        OP_RD_LCR:  rdata_nxt = lcr_r;
        OP_RD_MCR:  rdata_nxt = mcr_r;
        OP_RD_LSR:  rdata_nxt = has_data ? (LSR_TX_IDLE | LSR_DR) : LSR_TX_IDLE;
        OP_RD_ZERO: rdata_nxt = '0;
        OP_RD_SCR:  rdata_nxt = scr_r;
        OP_WR_OFF0: begin
          if (dlab) begin
            dll_nxt = cmd.data;
          end else begin
            txv_nxt  = 1'b1;
            txb_nxt  = cmd.data;
            thre_nxt = 1'b1;
            irq_nxt  = ier_r[IER_THRE_BIT] || (ier_r[IER_RDA_BIT] && has_data);
          end
        end
        OP_WR_OFF1: begin
          if (dlab) begin
            dlm_nxt = cmd.data;
          end else begin
            ier_nxt = cmd.data;
            if (cmd.data[IER_THRE_BIT] && !ier_r[IER_THRE_BIT]) thre_nxt = 1'b1;
            irq_nxt = (cmd.data[IER_THRE_BIT] && thre_nxt) ||
                      (cmd.data[IER_RDA_BIT] && has_data);
          end
        end
        OP_WR_FCR: begin
          fifo_on_nxt = cmd.data[FCR_EN_BIT];
          if (cmd.data[FCR_CLR_BIT]) begin
            head_nxt = '0;
            tail_nxt = '0;
            fill_nxt = '0;
          end
        end
        OP_WR_LCR:  lcr_nxt = cmd.data;
        OP_WR_MCR:  mcr_nxt = cmd.data;
        OP_WR_SCR:  scr_nxt = cmd.data;
        OP_NOP:     ;
        default:    ;
      endcase
    end
  end

  // Read address tracks the next head so the registered RAM output holds the head byte once head_r updates
  uartrf_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (cmd.data),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ier_r       <= '0;
      lcr_r       <= '0;
      mcr_r       <= '0;
      scr_r       <= '0;
      dll_r       <= '0;
      dlm_r       <= '0;
      fifo_on_r   <= 1'b0;
      thre_r      <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      byp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ier_r       <= ier_nxt;
      lcr_r       <= lcr_nxt;
      mcr_r       <= mcr_nxt;
      scr_r       <= scr_nxt;
      dll_r       <= dll_nxt;
      dlm_r       <= dlm_nxt;
      fifo_on_r   <= fifo_on_nxt;
      thre_r      <= thre_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      // write into the entry being read this cycle: RAM returns stale data
      byp_valid_r <= ram_we && (tail_r == head_nxt);
      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= cmd.data;
    if (fire) begin
      rdata_r <= rdata_nxt;
      txv_r   <= txv_nxt;
      txb_r   <= txb_nxt;
      irq_r   <= irq_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = rdata_r;
  assign out_tx_valid  = txv_r;
  assign out_tx_byte   = txb_r;
  assign out_irq_pulse = irq_r;

endmodule

// ===== rtl/uart_register_file_with_rx_fifo.sv =====
// Top level of the UART register file with receive FIFO.
// Depends on uartrf_pkg, uartrf_front, uartrf_cmd_queue and uartrf_back.
//
// Usage:
//   Each request on the in_ channel is a received line byte (in_action 0),
//   a bus read (1) or a bus write (2) at in_reg_offset. Every request
//   yields exactly one result on the out_ channel: read data, a transmit
//   byte with out_tx_valid, and an interrupt pulse.
//   The front classifies each request and pushes it into a two-entry
//   command queue; unless a held result stalls it, the back executes one
//   command per cycle against the register file and the receive FIFO and
//   holds its result in an output register.
//   Each accepted request is written into the queue; when the back takes
//   it, the result is registered and out_valid rises. The block takes one
//   request per cycle while out_ready stays high.
//   When out_ready is low, hold the result; the queue keeps taking
//   requests until both entries fill, then in_ready drops.
//   Reset (rst_n low, synchronous) empties the FIFO and queue, clears all
//   registers and drops out_valid. Received bytes that find the FIFO full
//   are dropped. FIFO storage is a RAM that needs no clearing pass.
module uart_register_file_with_rx_fifo (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [2:0] in_reg_offset,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_line_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_irq_pulse
);
  import uartrf_pkg::*;

  cmd_t in_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_ready;

  // Classify the request
  uartrf_front u_front (
    .action     (in_action),
    .reg_offset (in_reg_offset),
    .write_data (in_write_data),
    .line_byte  (in_line_byte),
    .cmd        (in_cmd)
  );

  // Decouple the front from the back
  uartrf_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (in_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // Execute against the register file and FIFO
  uartrf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_tx_valid  (out_tx_valid),
    .out_tx_byte   (out_tx_byte),
    .out_irq_pulse (out_irq_pulse)
  );

endmodule

// ===== test/tb_uart_register_file_with_rx_fifo.sv =====
// Self-checking testbench for the UART register file with receive FIFO.
// Depends on rtl/uartrf_pkg.sv and rtl/uart_register_file_with_rx_fifo.sv;
// predicts every response in-line and compares it on the out_ channel.
module tb_uart_register_file_with_rx_fifo;
  timeunit 1ns;
  timeprecision 1ps;
  import uartrf_pkg::*;

  // Action code that the block must ignore; it still answers with zeros.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS     = 280;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_pulse;
  } bus_response_t;

  // Clock, reset and the block's ports.
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_action = '0;
  logic [2:0] in_reg_offset = '0;
  logic [7:0] in_write_data = '0;
  logic [7:0] in_line_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic       out_tx_valid;
  logic [7:0] out_tx_byte;
  logic       out_irq_pulse;

  // Idle rates in percent of cycles, set per phase by the main sequence.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Receiver hold-off: a trigger starts one long stretch with out_ready low.
  event rx_hold_start;
  logic rx_hold = 1'b0;

  // Predicted register state of the UART.
  logic [7:0] ier = '0;
  logic [7:0] lcr = '0;
  logic [7:0] mcr = '0;
  logic [7:0] scr = '0;
  logic [7:0] dll = '0;
  logic [7:0] dlm = '0;
  logic       fifo_enabled = 1'b0;
  logic       thre_pending = 1'b0;
  logic [7:0] rx_bytes[$];

  // Responses predicted at acceptance and not yet seen on the out_ channel.
  bus_response_t awaited_responses[$];

  int mismatches = 0;
  int requests_sent = 0;
  int responses_checked = 0;
  int rx_bytes_dropped = 0;

  uart_register_file_with_rx_fifo dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_reg_offset (in_reg_offset),
    .in_write_data (in_write_data),
    .in_line_byte  (in_line_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_tx_valid  (out_tx_valid),
    .out_tx_byte   (out_tx_byte),
    .out_irq_pulse (out_irq_pulse)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Interrupt condition: THRE pending with its enable, or data with RDA enable.
  function automatic logic irq_due();
    return (ier[IER_THRE_BIT] && thre_pending) ||
           (ier[IER_RDA_BIT] && rx_bytes.size() != 0);
  endfunction

  // Advance the predicted state by one request and return its response.
  function automatic bus_response_t predict_bus_response(input logic [1:0] act,
                                                         input logic [2:0] off,
                                                         input logic [7:0] wdata,
                                                         input logic [7:0] lbyte);
    bus_response_t r;
    logic          dlab;
    logic [7:0]    iir;
    r    = '0;
    iir  = '0;
    dlab = lcr[LCR_DLAB_BIT];
    if (act == ACT_RX) begin
      // drop the byte when the FIFO is full
      if (rx_bytes.size() < RX_DEPTH) rx_bytes.push_back(lbyte);
      else rx_bytes_dropped++;
    end else if (act == ACT_READ) begin
      if (dlab && off <= OFF_IER) begin
        // divisor latch read: no interrupt, no side effect
        r.read_data = (off == OFF_RBR_THR) ? dll : dlm;
      end else begin
        case (off)
          OFF_RBR_THR: begin
            // an empty receive buffer reads as zero
            if (rx_bytes.size() != 0) r.read_data = rx_bytes.pop_front();
            r.irq_pulse = irq_due();
          end
          OFF_IER: r.read_data = ier;
          OFF_IIR_FCR: begin
            // received data outranks THRE; reading THRE clears it
            if (rx_bytes.size() != 0 && ier[IER_RDA_BIT]) begin
              iir = IIR_RX_DATA;
            end else if (thre_pending && ier[IER_THRE_BIT]) begin
              iir = IIR_THRE;
              thre_pending = 1'b0;
            end else begin
              iir = IIR_NONE;
            end
            if (fifo_enabled) iir = iir | IIR_FIFO_ID;
            r.read_data = iir;
          end
          OFF_LCR: r.read_data = lcr;
          OFF_MCR: r.read_data = mcr;
          OFF_LSR: r.read_data = (rx_bytes.size() != 0) ? (LSR_TX_IDLE | LSR_DR) : LSR_TX_IDLE;
          OFF_SCR: r.read_data = scr;
          default: r.read_data = '0;
        endcase
      end
    end else if (act == ACT_WRITE) begin
      if (dlab && off <= OFF_IER) begin
        if (off == OFF_RBR_THR) dll = wdata;
        else dlm = wdata;
      end else begin
        case (off)
          OFF_RBR_THR: begin
            r.tx_valid   = 1'b1;
            r.tx_byte    = wdata;
            thre_pending = 1'b1;
            r.irq_pulse  = irq_due();
          end
          OFF_IER: begin
            // a rising THRE enable arms the pending flag
            if (wdata[IER_THRE_BIT] && !ier[IER_THRE_BIT]) thre_pending = 1'b1;
            ier         = wdata;
            r.irq_pulse = irq_due();
          end
          OFF_IIR_FCR: begin
            fifo_enabled = wdata[FCR_EN_BIT];
            if (wdata[FCR_CLR_BIT]) rx_bytes.delete();
          end
          OFF_LCR: lcr = wdata;
          OFF_MCR: mcr = wdata;
          OFF_SCR: scr = wdata;
          default: ;  // LSR and MSR ignore writes
        endcase
      end
    end
    // the unused action code falls through: no state change, all zeros
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until accepted, then record its response.
  // Valid stays high into the next request unless an idle gap is drawn.
  task automatic send_request(input logic [1:0] act, input logic [2:0] off,
                              input logic [7:0] wdata, input logic [7:0] lbyte);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_reg_offset <= off;
    in_write_data <= wdata;
    in_line_byte  <= lbyte;
    do @(posedge clk); while (!in_ready);
    awaited_responses.push_back(predict_bus_response(act, off, wdata, lbyte));
    requests_sent++;
  endtask

  task automatic bus_write(input logic [2:0] off, input logic [7:0] wdata);
    send_request(ACT_WRITE, off, wdata, 8'($urandom_range(255)));
  endtask

  task automatic bus_read(input logic [2:0] off);
    send_request(ACT_READ, off, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic line_rx(input logic [7:0] lbyte);
    send_request(ACT_RX, 3'($urandom_range(7)), 8'($urandom_range(255)), lbyte);
  endtask

  // Drop valid and hold until every predicted response has been checked.
  task automatic wait_for_responses();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_responses.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random out_ready, one long hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always begin
    @(rx_hold_start);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted response with the oldest prediction.
  always @(posedge clk) begin
    bus_response_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_responses.size() == 0) begin
        $display("%0t: unexpected response, got read_data %02h tx_valid %0b tx_byte %02h irq %0b",
                 $time, out_read_data, out_tx_valid, out_tx_byte, out_irq_pulse);
        mismatches++;
      end else begin
        want = awaited_responses.pop_front();
        responses_checked++;
        report_field("read_data", want.read_data, out_read_data);
        report_field("tx_valid", 8'(want.tx_valid), 8'(out_tx_valid));
        report_field("tx_byte", want.tx_byte, out_tx_byte);
        report_field("irq_pulse", 8'(want.irq_pulse), 8'(out_irq_pulse));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk the register map once from reset: empty RBR, ignored writes,
  // THRE arming and clearing, FIFO id bits, divisor latches, unused action.
  task automatic test_register_map();
    bus_read(OFF_RBR_THR);        // empty receive buffer reads zero
    bus_read(OFF_IIR_FCR);
    bus_read(OFF_LSR);
    bus_read(OFF_MSR);
    bus_write(OFF_SCR, 8'hFF);
    bus_read(OFF_SCR);
    bus_write(OFF_LSR, 8'hFF);    // read-only, ignored
    bus_write(OFF_MSR, 8'hFF);    // read-only, ignored
    bus_write(OFF_IER, 8'h03);    // arm THRE, pulse interrupt
    bus_read(OFF_IIR_FCR);        // THRE reported and cleared
    bus_write(OFF_IIR_FCR, 8'h01);
    line_rx(8'hFF);
    line_rx(8'h00);
    bus_read(OFF_IIR_FCR);        // data pending with FIFO id bits
    bus_read(OFF_LSR);
    bus_read(OFF_RBR_THR);
    bus_read(OFF_RBR_THR);
    bus_write(OFF_RBR_THR, 8'hA5);
    bus_write(OFF_LCR, 8'h80);    // open divisor latches
    bus_write(OFF_RBR_THR, 8'h00);
    bus_write(OFF_IER, 8'hFF);
    bus_read(OFF_RBR_THR);
    bus_read(OFF_IER);
    bus_write(OFF_LCR, 8'h7F);
    bus_read(OFF_LCR);
    send_request(ACT_UNUSED, 3'h7, 8'hFF, 8'hFF);
    line_rx(8'h5A);
    bus_write(OFF_IIR_FCR, 8'hFE); // clear the FIFO, turn it off
    bus_read(OFF_LSR);
    bus_write(OFF_LCR, 8'h00);
  endtask

  // Hold the receiver off while requests keep coming so the block fills and
  // stalls in_ready; overflow the receive FIFO on the way, then drain it.
  task automatic test_backpressure_and_overflow();
    int saved_send;
    int i;
    saved_send    = send_idle_pct;
    send_idle_pct = 0;
    bus_write(OFF_LCR, 8'h03);
    bus_write(OFF_IER, 8'h01);
    -> rx_hold_start;
    for (i = 0; i < RX_DEPTH + 4; i++) line_rx(8'($urandom_range(255)));
    for (i = 0; i < RX_DEPTH + 2; i++) bus_read(OFF_RBR_THR);
    wait_for_responses();
    send_idle_pct = saved_send;
  endtask

  // Mostly well-formed traffic: receive bursts, RBR drains, interrupt and
  // FIFO control, with random single requests and unused actions mixed in.
  task automatic test_random_traffic(input int count);
    int done;
    int pick;
    int burst;
    int i;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        burst = $urandom_range(20, 1);
        for (i = 0; i < burst; i++) line_rx(8'($urandom_range(255)));
        done += burst;
      end else if (pick < 45) begin
        burst = $urandom_range(20, 1);
        for (i = 0; i < burst; i++) bus_read(OFF_RBR_THR);
        done += burst;
      end else begin
        if (pick < 52) bus_read(OFF_IIR_FCR);
        else if (pick < 57) bus_write(OFF_LCR, 8'($urandom_range(255)) &
                                      (($urandom_range(3) == 0) ? 8'hFF : 8'h7F));
        else if (pick < 63) bus_write(OFF_IER, 8'($urandom_range(255)));
        else if (pick < 68) bus_write(OFF_IIR_FCR, 8'($urandom_range(255)));
        else if (pick < 74) bus_write(OFF_RBR_THR, 8'($urandom_range(255)));
        else if (pick < 97) send_request(2'($urandom_range(2)), 3'($urandom_range(7)),
                                         8'($urandom_range(255)), 8'($urandom_range(255)));
        else send_request(ACT_UNUSED, 3'($urandom_range(7)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
        if (pick < 97) done++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sender rarely idle, receiver mostly stalled
    send_idle_pct = 14;
    recv_idle_pct = 81;
    test_register_map();
    test_backpressure_and_overflow();
    test_random_traffic(RANDOM_ITEMS);
    wait_for_responses();

    // sender mostly idle, receiver rarely stalled
    send_idle_pct = 81;
    recv_idle_pct = 14;
    test_random_traffic(RANDOM_ITEMS);
    wait_for_responses();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS);
    wait_for_responses();
    repeat (4) @(posedge clk);

    $display("Sent %0d requests, checked %0d responses, %0d receive bytes dropped on full FIFO.",
             requests_sent, responses_checked, rx_bytes_dropped);
    $display("Covered register map, divisor latches, THRE and RDA interrupts, backpressure.");
    if (mismatches == 0 && awaited_responses.size() == 0) begin
      $display("PASS uart_register_file_with_rx_fifo");
    end else begin
      $display("%0d mismatches, %0d responses never arrived",
               mismatches, awaited_responses.size());
      $display("FAIL uart_register_file_with_rx_fifo");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #5ms;
    $display("Timeout with %0d responses outstanding", awaited_responses.size());
    $display("FAIL uart_register_file_with_rx_fifo");
    $finish;
  end

endmodule
